/* rtl/core/lcdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lcdw_pkg;

   localparam int COLUMNS    = 16;
   localparam int ROWS       = 2;
   localparam int COL_W      = 5;
   localparam int ROW_W      = 2;
   localparam int ACC_W      = 6;
   localparam int STEP_W     = 5;
   localparam int CHAR_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] TAB_STEP_RESET = 5'd4;
   localparam logic              CSR_IDX_TAB_STEP = 1'b0;

   localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;
   localparam logic [CHAR_W-1:0] ADDR_MASK    = 8'h7F;

   typedef enum logic [2:0] {
      CC_BELL,
      CC_BACK,
      CC_TAB,
      CC_NEWLINE,
      CC_FORMFEED,
      CC_PRINT
   } char_class_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAB_STEP,
      S_ADDR,
      S_CLEAR,
      S_DATA,
      S_NL_ADDR,
      S_NL_SPACE,
      S_NL_READDR
   } ctrl_state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_BACK,
      CUR_HOME,
      CUR_NEXT_ROW,
      CUR_INC,
      CUR_TAB
   } cursor_op_type;

   typedef enum logic [1:0] {
      OUT_ADDR,
      OUT_SPACE,
      OUT_CLEAR,
      OUT_CHAR
   } out_sel_type;

   typedef struct packed {
      logic          load_char;
      cursor_op_type cursor_op;
      logic          acc_clear;
      logic          acc_add;
      logic          cnt_clear;
      logic          cnt_inc;
      logic          out_load;
      out_sel_type   out_sel;
      logic          out_last;
   } dp_cmd_type;

   typedef struct packed {
      char_class_type in_class;
      char_class_type char_class;
      logic           col_full;
      logic           tab_done;
      logic           space_done;
      logic           out_free;
   } dp_status_type;

   function automatic char_class_type classify(logic [CHAR_W-1:0] c);
      char_class_type cls;
      case (c)
         CH_BELL:      cls = CC_BELL;
         CH_BACKSPACE: cls = CC_BACK;
         CH_TAB:       cls = CC_TAB;
         CH_NEWLINE:   cls = CC_NEWLINE;
         CH_FORMFEED:  cls = CC_FORMFEED;
         default:      cls = CC_PRINT;
      endcase
      return cls;
   endfunction

   function automatic logic [CHAR_W-1:0] row_base(logic [ROW_W-1:0] row);
      logic [CHAR_W-1:0] base;
      case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

   function automatic logic [CHAR_W-1:0] set_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
      logic [CHAR_W-1:0] sum;
      sum = CHAR_W'(col) + row_base(row);
      return CMD_SET_ADDR | (sum & ADDR_MASK);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/lcdw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lcdw_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [lcdw_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic [lcdw_pkg::STEP_W-1:0]  tab_step,
   input  wire lcdw_pkg::dp_cmd_type         cmd,
   output lcdw_pkg::dp_status_type           status,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_is_data,
   output logic [lcdw_pkg::CHAR_W-1:0]       rsp_lcd_byte,
   output logic                              rsp_last
);
   import lcdw_pkg::*;

   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [COL_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_data_ff, is_data_in;
   logic [CHAR_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;

   logic [ROW_W-1:0]  row_next;
   logic [STEP_W-1:0] step_eff;
   logic              out_free;

   assign row_next = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign step_eff = (tab_step == '0) ? STEP_W'(1) : tab_step;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      char_in = cmd.load_char ? req_char_code : char_ff;
      acc_in  = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(step_eff);
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.cursor_op)
         CUR_BACK: begin
            col_in = (col_ff == '0) ? '0 : col_ff - 1'b1;
         end
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         CUR_NEXT_ROW: begin
            col_in = '0;
            row_in = row_next;
         end
         CUR_INC: begin
            col_in = col_ff + 1'b1;
         end
         CUR_TAB: begin
            if (acc_ff >= ACC_W'(COLUMNS)) begin
               col_in = '0;
               row_in = row_next;
            end else begin
               col_in = acc_ff[COL_W-1:0];
            end
         end
         default: begin
            col_in = col_ff;
            row_in = row_ff;
         end
      endcase
   end

   always_comb begin
      is_data_in = is_data_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      if (cmd.out_load) begin
         last_in = cmd.out_last;
         case (cmd.out_sel)
            OUT_ADDR: begin
               is_data_in = 1'b0;
               byte_in    = set_addr(col_ff, row_ff);
            end
            OUT_SPACE: begin
               is_data_in = 1'b1;
               byte_in    = CH_SPACE;
            end
            OUT_CLEAR: begin
               is_data_in = 1'b0;
               byte_in    = CMD_CLEAR;
            end
            default: begin
               is_data_in = 1'b1;
               byte_in    = char_ff;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      is_data_ff <= is_data_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   always_comb begin
      status.in_class   = classify(req_char_code);
      status.char_class = classify(char_ff);
      status.col_full   = (col_ff >= COL_W'(COLUMNS));
      status.tab_done   = (acc_ff > ACC_W'(col_ff));
      status.space_done = (cnt_ff == COL_W'(COLUMNS - 1));
      status.out_free   = out_free;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_data  = is_data_ff;
   assign rsp_lcd_byte = byte_ff;
   assign rsp_last     = last_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(COLUMNS))
      else $error("cursor column beyond line end");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(ROWS - 1))
      else $error("cursor row beyond last row");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("output word overwritten before taken");

endmodule
`default_nettype wire

/* rtl/core/lcdw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lcdw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lcdw_pkg::dp_status_type status,
   output lcdw_pkg::dp_cmd_type         cmd
);
   import lcdw_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (status.in_class)
                  CC_BELL:     state_in = S_IDLE;
                  CC_BACK:     state_in = S_ADDR;
                  CC_TAB:      state_in = S_TAB_STEP;
                  CC_NEWLINE:  state_in = S_NL_ADDR;
                  CC_FORMFEED: state_in = S_CLEAR;
                  default:     state_in = status.col_full ? S_NL_ADDR : S_DATA;
               endcase
            end
         end
         S_TAB_STEP: begin
            if (status.tab_done) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR, S_CLEAR, S_DATA: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_NL_ADDR: begin
            if (status.out_free) begin
               state_in = S_NL_SPACE;
            end
         end
         S_NL_SPACE: begin
            if (status.out_free && status.space_done) begin
               state_in = S_NL_READDR;
            end
         end
         S_NL_READDR: begin
            if (status.out_free) begin
               state_in = (status.char_class == CC_NEWLINE) ? S_IDLE : S_DATA;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.cursor_op = CUR_HOLD;
      cmd.out_sel   = OUT_ADDR;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_char = 1'b1;
               unique case (status.in_class)
                  CC_BELL:     cmd.cursor_op = CUR_HOLD;
                  CC_BACK:     cmd.cursor_op = CUR_BACK;
                  CC_TAB:      cmd.acc_clear = 1'b1;
                  CC_NEWLINE:  cmd.cursor_op = CUR_NEXT_ROW;
                  CC_FORMFEED: cmd.cursor_op = CUR_HOME;
                  default: begin
                     cmd.cursor_op = status.col_full ? CUR_NEXT_ROW : CUR_HOLD;
                  end
               endcase
            end
         end
         S_TAB_STEP: begin
            if (status.tab_done) begin
               cmd.cursor_op = CUR_TAB;
            end else begin
               cmd.acc_add = 1'b1;
            end
         end
         S_ADDR: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = OUT_ADDR;
            cmd.out_last = 1'b1;
         end
         S_CLEAR: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = OUT_CLEAR;
            cmd.out_last = 1'b1;
         end
         S_DATA: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = OUT_CHAR;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.cursor_op = CUR_INC;
            end
         end
         S_NL_ADDR: begin
            cmd.out_load  = status.out_free;
            cmd.out_sel   = OUT_ADDR;
            cmd.cnt_clear = status.out_free;
         end
         S_NL_SPACE: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = OUT_SPACE;
            cmd.cnt_inc  = status.out_free;
         end
         S_NL_READDR: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = OUT_ADDR;
            cmd.out_last = (status.char_class == CC_NEWLINE);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_bell_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && status.in_class == CC_BELL)
      |=> (state_ff == S_IDLE && !cmd.out_load))
      else $error("bell produced work");

   a_tab_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAB_STEP && status.tab_done) |=> state_ff == S_ADDR)
      else $error("tab stop search did not finish");

   a_spaces_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NL_SPACE && status.out_free && status.space_done)
      |=> state_ff == S_NL_READDR)
      else $error("line blanking did not end");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) |=> state_ff == S_IDLE)
      else $error("final word not followed by idle");

endmodule
`default_nettype wire

/* rtl/core/char_lcd_terminal_writer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Character LCD terminal writer. Each accepted character updates the cursor
// and produces the instruction/data words for the display controller, one
// word per cycle through a registered output while the output is not stalled.
// A bell produces no word; backspace, form feed and ordinary characters
// produce one word; a newline blanks the next row (as does a character that
// wraps a full line); for a tab the next tab stop is found by adding the step
// once per cycle. The next character is taken as soon as the final word is
// loaded into the output register.
module char_lcd_terminal_writer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [lcdw_pkg::CHAR_W-1:0]      req_char_code,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_is_data,
   output logic [lcdw_pkg::CHAR_W-1:0]           rsp_lcd_byte,
   output logic                                  rsp_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lcdw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lcdw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lcdw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import lcdw_pkg::*;

   logic [STEP_W-1:0] tab_step_ff, tab_step_in;
   logic              csr_sel_tab;
   dp_cmd_type        cmd;
   dp_status_type     status;

   assign csr_sel_tab = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_TAB_STEP);
   assign csr_pready  = 1'b1;

   always_comb begin
      tab_step_in = tab_step_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_tab) begin
         tab_step_in = csr_pwdata[STEP_W-1:0];
      end
      csr_prdata = csr_sel_tab ? CSR_DATA_W'(tab_step_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_step_ff <= TAB_STEP_RESET;
      end else begin
         tab_step_ff <= tab_step_in;
      end
   end

   lcdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcdw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .tab_step      (tab_step_ff),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_is_data   (rsp_is_data),
      .rsp_lcd_byte  (rsp_lcd_byte),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
